>>> hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes of the block buffer cache tag and replacement engine.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef enum logic [2:0] {
    OP_GET         = 3'd0,
    OP_PUT         = 3'd1,
    OP_MARK_DIRTY  = 3'd2,
    OP_MARK_CLEAN  = 3'd3,
    OP_INVALIDATE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ALL_HELD = 2'd1,
    ST_UNHELD   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  localparam logic [1:0] FETCH_NORMAL   = 2'd0;
  localparam logic [1:0] FETCH_PREFETCH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCMP,
    S_HIT_CHK,
    S_UNLINK,
    S_MISS_RD,
    S_MISS_CHK,
    S_MISS_FIN,
    S_PUT_CHK,
    S_LINK1,
    S_LINK2,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    SK_GET,
    SK_FLUSH,
    SK_INVAL
  } scan_kind_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] dev;
    logic [31:0] block_num;
    logic [1:0]  fetch_mode;
    logic        no_reuse;
    logic [5:0]  slot_in;
  } req_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        read_request;
    logic        flush_request;
    logic [15:0] flush_dev;
    logic [1:0]  status;
    logic [6:0]  held_entries;
  } rsp_t;

  // Search key for the shared tag comparator
  typedef struct packed {
    logic [15:0] dev;
    logic [31:0] blk;
    logic        use_blk;
  } cmp_key_t;

endpackage

>>> hw/rtl/bbc_stream_if.sv
// ----------------------------------------------------------------------------
// bbc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bbc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/bbc_tag_cmp.sv
// ----------------------------------------------------------------------------
// bbc_tag_cmp
// Shared tag comparator: device match, optionally with block match.
// ----------------------------------------------------------------------------
module bbc_tag_cmp
  import bbc_pkg::*;
(
  input  logic [15:0] tag_dev,
  input  logic [31:0] tag_blk,
  input  cmp_key_t    key,
  output logic        match
);
  always_comb begin
    match = (tag_dev == key.dev) && (!key.use_blk || (tag_blk == key.blk));
  end
endmodule

>>> hw/rtl/block_buffer_cache_lru_unit.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit
// Tag search, reference counting and LRU list upkeep of a block buffer cache.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                  Transaction when
// req      in   op, dev, block_num, fetch_mode, ...      req.valid & req.ready
// rsp      out  slot, hit, read/flush request, status    rsp.valid & rsp.ready
// cfg      in   ram_device (16 bit)                      cfg.valid & cfg.ready
//
// Get scans the tags one entry per pass of the shared comparator: a valid
// entry is read in S_SCAN and compared in S_SCMP, an invalid one is skipped
// in S_SCAN. A miss with a dirty victim adds a second scan over the tags, and
// invalidate scans every entry. Put relinks a released entry in S_LINK1/2.
// One item is in work at a time; req.ready is high only when idle.
// Reset is synchronous; the list and count RAMs read their reset values through
// per-entry init flags, so no clearing pass is needed.
// A finished result moves to the output register; while an older one still
// waits there, the engine holds in its last state.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit
  import bbc_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int REF_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  bbc_stream_if.sink   req,
  bbc_stream_if.source rsp,
  bbc_stream_if.sink   cfg
);
  localparam int AW = $clog2(ENTRIES);
  localparam int IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] NIL = IW'(ENTRIES);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  state_e           state, state_next;
  scan_kind_e       kind;
  logic [15:0]      ram_device;
  logic [IW-1:0]    idx;
  logic [AW-1:0]    ent;
  logic [IW-1:0]    head, tail;
  logic [IW-1:0]    held;
  logic             miss, front;
  logic [2:0]       r_op;
  logic [15:0]      r_dev;
  logic [31:0]      r_blk;
  logic [1:0]       r_mode;
  logic             r_no_reuse;
  logic [ENTRIES-1:0] tag_valid, dirty, rc_init, nx_init, pv_init;
  logic             rc_ok, nx_ok, pv_ok;
  logic [AW-1:0]    lk_aq;
  logic             rsp_valid;
  rsp_t             res;
  rsp_t             res_out;
  rsp_t             rsp_q;

  // RAM ports
  logic                rc_we, tg_we, nx_we, pv_we;
  logic [AW-1:0]       rc_waddr, tg_waddr, nx_waddr, pv_waddr;
  logic [AW-1:0]       rc_raddr, tg_raddr, lk_raddr;
  logic [REF_BITS-1:0] rc_wdata, rc_rdata;
  logic [47:0]         tg_wdata, tg_rdata;
  logic [IW-1:0]       nx_wdata, nx_rdata, pv_wdata, pv_rdata;

  logic [REF_BITS-1:0] rc_val;
  logic [IW-1:0]       nx_val, pv_val;
  cmp_key_t            key;
  logic                match;
  logic                slot_oob;

  bbc_ram #(.WIDTH(REF_BITS), .DEPTH(ENTRIES)) u_rc (
    .clk, .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata), .raddr(rc_raddr), .rdata(rc_rdata)
  );
  bbc_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_tag (
    .clk, .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata), .raddr(tg_raddr), .rdata(tg_rdata)
  );
  bbc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata), .raddr(lk_raddr), .rdata(nx_rdata)
  );
  bbc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev (
    .clk, .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata), .raddr(lk_raddr), .rdata(pv_rdata)
  );

  bbc_tag_cmp u_cmp (
    .tag_dev(tg_rdata[47:32]), .tag_blk(tg_rdata[31:0]), .key, .match
  );

  // Entries never written read as their reset values
  assign rc_val = rc_ok ? rc_rdata : '0;
  assign nx_val = nx_ok ? nx_rdata : IW'(lk_aq) + IW'(1);
  assign pv_val = pv_ok ? pv_rdata : ((lk_aq == '0) ? NIL : IW'(lk_aq) - IW'(1));

  assign slot_oob  = 32'(req.data.slot_in) >= 32'(ENTRIES);
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

  always_comb begin
    res_out = res;
    res_out.held_entries = 7'(held);
  end

  always_comb begin
    state_next = state;
    rc_we = 1'b0; tg_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
    rc_waddr = ent; tg_waddr = ent; nx_waddr = ent; pv_waddr = ent;
    rc_wdata = '0; tg_wdata = {r_dev, r_blk}; nx_wdata = '0; pv_wdata = '0;
    rc_raddr = ent; tg_raddr = ent; lk_raddr = ent;
    key.dev = r_dev;
    key.blk = r_blk;
    key.use_blk = (kind == SK_GET);
    case (state)
      S_IDLE: begin
        rc_raddr = AW'(req.data.slot_in);
        tg_raddr = AW'(req.data.slot_in);
        if (req.valid) begin
          case (req.data.op)
            OP_GET, OP_INVALIDATE: state_next = S_SCAN;
            OP_PUT:                state_next = slot_oob ? S_DONE : S_PUT_CHK;
            default:               state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        tg_raddr = idx[AW-1:0];
        lk_raddr = head[AW-1:0];
        if (idx == NIL) begin
          case (kind)
            SK_GET:   state_next = (head == NIL) ? S_DONE : S_UNLINK;
            SK_FLUSH: state_next = S_MISS_FIN;
            default:  state_next = S_DONE;
          endcase
        end else if (tag_valid[idx[AW-1:0]]) begin
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        rc_raddr = idx[AW-1:0];
        if (kind == SK_FLUSH) begin
          key.dev = res.flush_dev;
        end
        state_next = (match && kind == SK_GET) ? S_HIT_CHK : S_SCAN;
      end
      S_HIT_CHK: begin
        if (rc_val == REF_MAX) begin
          state_next = S_DONE;
        end else begin
          rc_we    = 1'b1;
          rc_wdata = rc_val + REF_BITS'(1);
          state_next = (rc_val == '0) ? S_UNLINK : S_DONE;
        end
      end
      S_UNLINK: begin
        // Bypass the entry: prev's next and next's prev
        nx_we    = (pv_val != NIL);
        nx_waddr = pv_val[AW-1:0];
        nx_wdata = nx_val;
        pv_we    = (nx_val != NIL);
        pv_waddr = nx_val[AW-1:0];
        pv_wdata = pv_val;
        state_next = miss ? S_MISS_RD : S_DONE;
      end
      S_MISS_RD:  state_next = S_MISS_CHK;
      S_MISS_CHK: state_next = (tag_valid[ent] && dirty[ent]) ? S_SCAN : S_MISS_FIN;
      S_MISS_FIN: begin
        tg_we    = 1'b1;
        rc_we    = 1'b1;
        rc_wdata = REF_BITS'(1);
        state_next = S_DONE;
      end
      S_PUT_CHK: begin
        key.dev = ram_device;
        key.use_blk = 1'b0;
        if (rc_val == '0) begin
          state_next = S_DONE;
        end else begin
          rc_we    = 1'b1;
          rc_wdata = rc_val - REF_BITS'(1);
          state_next = (rc_val == REF_BITS'(1)) ? S_LINK1 : S_DONE;
        end
      end
      S_LINK1: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wdata = front ? head : NIL;
        pv_wdata = front ? NIL : tail;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        pv_we    = front && (head != NIL);
        pv_waddr = head[AW-1:0];
        pv_wdata = IW'(ent);
        nx_we    = !front && (tail != NIL);
        nx_waddr = tail[AW-1:0];
        nx_wdata = IW'(ent);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rc_ok <= rc_init[rc_raddr];
    nx_ok <= nx_init[lk_raddr];
    pv_ok <= pv_init[lk_raddr];
    lk_aq <= lk_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_device <= 16'hFFFF;
      head       <= '0;
      tail       <= IW'(ENTRIES - 1);
      held       <= '0;
      tag_valid  <= '0;
      dirty      <= '0;
      rc_init    <= '0;
      nx_init    <= '0;
      pv_init    <= '0;
      rsp_valid  <= 1'b0;
      kind       <= SK_GET;
      miss       <= 1'b0;
      front      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        ram_device <= cfg.data;
      end
      if (rc_we) rc_init[rc_waddr] <= 1'b1;
      if (nx_we) nx_init[nx_waddr] <= 1'b1;
      if (pv_we) pv_init[pv_waddr] <= 1'b1;
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            miss <= 1'b0;
            kind <= (req.data.op == OP_INVALIDATE) ? SK_INVAL : SK_GET;
            if (!slot_oob && (req.data.op == OP_MARK_DIRTY || req.data.op == OP_MARK_CLEAN)) begin
              dirty[AW'(req.data.slot_in)] <= (req.data.op == OP_MARK_DIRTY);
            end
          end
        end
        S_SCAN: begin
          if (idx == NIL) begin
            if (kind == SK_GET && head != NIL) begin
              miss <= 1'b1;
            end
          end
        end
        S_SCMP: begin
          if (match) begin
            case (kind)
              SK_FLUSH: dirty[idx[AW-1:0]] <= 1'b0;
              SK_INVAL: tag_valid[idx[AW-1:0]] <= 1'b0;
              default: ;
            endcase
          end
        end
        S_HIT_CHK: begin
          if (rc_val != REF_MAX && rc_val == '0) begin
            held <= held + IW'(1);
          end
        end
        S_UNLINK: begin
          if (pv_val == NIL) head <= nx_val;
          if (nx_val == NIL) tail <= pv_val;
        end
        S_MISS_CHK: begin
          if (tag_valid[ent] && dirty[ent]) begin
            kind <= SK_FLUSH;
          end
        end
        S_MISS_FIN: begin
          dirty[ent]     <= 1'b0;
          tag_valid[ent] <= (r_mode != FETCH_PREFETCH);
          held           <= held + IW'(1);
        end
        S_PUT_CHK: begin
          if (rc_val == REF_BITS'(1)) begin
            if (held != '0) held <= held - IW'(1);
            front <= r_no_reuse || (tag_valid[ent] && match);
          end
        end
        S_LINK2: begin
          if (front) begin
            if (head == NIL) tail <= IW'(ent);
            head <= IW'(ent);
          end else begin
            if (tail == NIL) head <= IW'(ent);
            tail <= IW'(ent);
          end
        end
        default: ;
      endcase
    end
  end

  // Request copy, scan index, result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        r_op       <= req.data.op;
        r_dev      <= req.data.dev;
        r_blk      <= req.data.block_num;
        r_mode     <= req.data.fetch_mode;
        r_no_reuse <= req.data.no_reuse;
        ent        <= AW'(req.data.slot_in);
        idx        <= '0;
        res.slot          <= '0;
        res.hit           <= 1'b0;
        res.read_request  <= 1'b0;
        res.flush_request <= 1'b0;
        res.flush_dev     <= '0;
        res.status        <= (req.data.op == OP_PUT && slot_oob) ? ST_UNHELD : ST_OK;
      end
      S_SCAN: begin
        if (idx == NIL) begin
          if (kind == SK_GET) begin
            if (head == NIL) begin
              res.status <= ST_ALL_HELD;
            end else begin
              ent <= head[AW-1:0];
            end
          end
        end else if (!tag_valid[idx[AW-1:0]]) begin
          idx <= idx + IW'(1);
        end
      end
      S_SCMP: begin
        if (match && kind == SK_GET) begin
          ent      <= idx[AW-1:0];
          res.slot <= 6'(idx[AW-1:0]);
          res.hit  <= 1'b1;
        end else begin
          idx <= idx + IW'(1);
        end
      end
      S_HIT_CHK: begin
        if (rc_val == REF_MAX) res.status <= ST_OVERFLOW;
      end
      S_MISS_CHK: begin
        if (tag_valid[ent] && dirty[ent]) begin
          res.flush_request <= 1'b1;
          res.flush_dev     <= tg_rdata[47:32];
          idx               <= '0;
        end
      end
      S_MISS_FIN: begin
        res.slot         <= 6'(ent);
        res.read_request <= (r_mode == FETCH_NORMAL);
      end
      S_PUT_CHK: begin
        if (rc_val == '0) res.status <= ST_UNHELD;
      end
      S_DONE: begin
        res.held_entries <= 7'(held);
        // Hand the finished transaction to the output register once it is free
        if (!rsp_valid || rsp.ready) begin
          rsp_q <= res_out;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= IW'(ENTRIES))
    else $error("held count above entry count");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && held == '0) |-> head != NIL)
    else $error("LRU list empty while nothing is held");

  a_list_empty_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && head == NIL) |-> held == IW'(ENTRIES))
    else $error("LRU list empty but entries not all held");

  a_flush_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && kind == SK_FLUSH) |-> res.flush_request)
    else $error("flush scan without flush request");

  a_op_known: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT_CHK) |-> r_op == OP_PUT)
    else $error("put check on a non-put transaction");
`endif
endmodule

>>> verif/tb_block_buffer_cache_lru_unit.sv
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru_unit
// Self-checking testbench of the block buffer cache tag and replacement engine.
// A cycle-free predictor tracks tags, counts, dirty marks and the LRU list, and
// each response transaction is compared with the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru_unit;
  import bbc_pkg::*;

  localparam int NENT = 64;
  localparam int CNT_MAX = 255;

  logic clk;
  logic rst;

  bbc_stream_if #(.T(req_t))        req_if ();
  bbc_stream_if #(.T(rsp_t))        rsp_if ();
  bbc_stream_if #(.T(logic [15:0])) cfg_if ();

  block_buffer_cache_lru_unit #(.ENTRIES(NENT), .REF_BITS(8)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow copy of the engine state
  logic [15:0] sh_dev [NENT];
  logic [31:0] sh_blk [NENT];
  bit          sh_valid [NENT];
  int          sh_cnt [NENT];
  bit          sh_dirty [NENT];
  int          sh_next [NENT];
  int          sh_prev [NENT];
  int          sh_head, sh_tail, sh_held;
  logic [15:0] sh_ram_dev;

  rsp_t expected_rsp_q [$];
  int   fail_cnt;
  int   item_cnt, rsp_cnt, hit_cnt, miss_cnt, flush_cnt, full_cnt, ovf_cnt, unheld_cnt;
  int   rsp_hold_cycles;
  bit   no_idle;

  function automatic void list_unlink(int e);
    int n, p;
    n = sh_next[e];
    p = sh_prev[e];
    if (p < NENT) sh_next[p] = n; else sh_head = n;
    if (n < NENT) sh_prev[n] = p; else sh_tail = p;
    sh_next[e] = NENT;
    sh_prev[e] = NENT;
  endfunction

  function automatic void list_push_front(int e);
    sh_prev[e] = NENT;
    sh_next[e] = sh_head;
    if (sh_head < NENT) sh_prev[sh_head] = e; else sh_tail = e;
    sh_head = e;
  endfunction

  function automatic void list_push_back(int e);
    sh_next[e] = NENT;
    sh_prev[e] = sh_tail;
    if (sh_tail < NENT) sh_next[sh_tail] = e; else sh_head = e;
    sh_tail = e;
  endfunction

  function automatic rsp_t predict_cache_op(req_t r);
    rsp_t o;
    int   found, v, s;
    o = '0;
    found = NENT;
    s = r.slot_in;
    case (r.op)
      OP_GET: begin
        for (int i = 0; i < NENT; i++) begin
          if (found == NENT && sh_valid[i] && sh_dev[i] == r.dev && sh_blk[i] == r.block_num)
            found = i;
        end
        if (found < NENT) begin
          o.slot = 6'(found);
          o.hit = 1'b1;
          if (sh_cnt[found] >= CNT_MAX) begin
            o.status = ST_OVERFLOW;
          end else begin
            if (sh_cnt[found] == 0) begin
              list_unlink(found);
              sh_held++;
            end
            sh_cnt[found]++;
          end
        end else if (sh_head >= NENT) begin
          o.status = ST_ALL_HELD;
        end else begin
          v = sh_head;
          list_unlink(v);
          if (sh_valid[v] && sh_dirty[v]) begin
            o.flush_request = 1'b1;
            o.flush_dev = sh_dev[v];
            for (int i = 0; i < NENT; i++)
              if (sh_valid[i] && sh_dev[i] == sh_dev[v]) sh_dirty[i] = 1'b0;
          end
          sh_dirty[v] = 1'b0;
          sh_dev[v] = r.dev;
          sh_blk[v] = r.block_num;
          sh_valid[v] = (r.fetch_mode != FETCH_PREFETCH);
          sh_cnt[v] = 1;
          sh_held++;
          o.read_request = (r.fetch_mode == FETCH_NORMAL);
          o.slot = 6'(v);
        end
      end
      OP_PUT: begin
        if (sh_cnt[s] == 0) begin
          o.status = ST_UNHELD;
        end else begin
          sh_cnt[s]--;
          if (sh_cnt[s] == 0) begin
            if (sh_held > 0) sh_held--;
            if (r.no_reuse || (sh_valid[s] && sh_dev[s] == sh_ram_dev)) list_push_front(s);
            else list_push_back(s);
          end
        end
      end
      OP_MARK_DIRTY: sh_dirty[s] = 1'b1;
      OP_MARK_CLEAN: sh_dirty[s] = 1'b0;
      OP_INVALIDATE: begin
        for (int i = 0; i < NENT; i++)
          if (sh_valid[i] && sh_dev[i] == r.dev) sh_valid[i] = 1'b0;
      end
      default: ;
    endcase
    o.held_entries = 7'(sh_held);
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one request transaction and queue its predicted response
  task automatic send_op(input req_t r, output rsp_t pred);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred = predict_cache_op(r);
    expected_rsp_q.push_back(pred);
    item_cnt++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_ram_dev(input logic [15:0] v);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sh_ram_dev = v;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic req_t mk_op(op_e op, logic [15:0] dev, logic [31:0] blk,
                                 logic [1:0] mode, logic no_reuse, logic [5:0] s);
    req_t r;
    r.op = op;
    r.dev = dev;
    r.block_num = blk;
    r.fetch_mode = mode;
    r.no_reuse = no_reuse;
    r.slot_in = s;
    return r;
  endfunction

  // Response side: random stalls, with an optional long hold-off
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (rsp_hold_cycles > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold_cycles <= rsp_hold_cycles - 1;
    end else if (no_idle) begin
      rsp_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(15, 60);
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) < 75);
    end
  end

  always @(posedge clk) begin
    rsp_t e, a;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      a = rsp_if.data;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: response with none expected: %p", $time, a);
        fail_cnt++;
      end else begin
        e = expected_rsp_q.pop_front();
        rsp_cnt++;
        if (a.slot !== e.slot) begin
          $display("%0t: slot exp %0d act %0d", $time, e.slot, a.slot); fail_cnt++;
        end
        if (a.hit !== e.hit) begin
          $display("%0t: hit exp %0d act %0d", $time, e.hit, a.hit); fail_cnt++;
        end
        if (a.read_request !== e.read_request) begin
          $display("%0t: read_request exp %0d act %0d", $time, e.read_request,
                   a.read_request); fail_cnt++;
        end
        if (a.flush_request !== e.flush_request) begin
          $display("%0t: flush_request exp %0d act %0d", $time, e.flush_request,
                   a.flush_request); fail_cnt++;
        end
        if (a.flush_dev !== e.flush_dev) begin
          $display("%0t: flush_dev exp %0d act %0d", $time, e.flush_dev, a.flush_dev);
          fail_cnt++;
        end
        if (a.status !== e.status) begin
          $display("%0t: status exp %0d act %0d", $time, e.status, a.status); fail_cnt++;
        end
        if (a.held_entries !== e.held_entries) begin
          $display("%0t: held_entries exp %0d act %0d", $time, e.held_entries,
                   a.held_entries); fail_cnt++;
        end
        if (e.hit) hit_cnt++;
        if (e.flush_request) flush_cnt++;
        if (e.read_request) miss_cnt++;
        if (e.status == ST_ALL_HELD) full_cnt++;
        if (e.status == ST_OVERFLOW) ovf_cnt++;
        if (e.status == ST_UNHELD) unheld_cnt++;
      end
    end
  end

  task automatic test_directed();
    rsp_t p;
    req_t r;
    int a;
    send_op(mk_op(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, FETCH_NORMAL, 0, 0), p);
    a = p.slot;
    send_op(mk_op(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 2'd1, 0, 0), p);   // hit
    send_op(mk_op(OP_GET, 16'h0000, 32'h0, 2'd1, 0, 0), p);
    send_op(mk_op(OP_GET, 16'h0001, 32'h5, FETCH_PREFETCH, 0, 0), p);
    send_op(mk_op(OP_GET, 16'h0001, 32'h5, 2'd3, 0, 0), p);          // prefetched tag misses
    send_op(mk_op(OP_MARK_DIRTY, 0, 0, 0, 0, a[5:0]), p);
    send_op(mk_op(OP_PUT, 0, 0, 0, 0, a[5:0]), p);
    send_op(mk_op(OP_PUT, 0, 0, 0, 1'b1, a[5:0]), p);                // no-reuse to head
    send_op(mk_op(OP_PUT, 0, 0, 0, 0, a[5:0]), p);                   // unheld
    send_op(mk_op(OP_GET, 16'h0002, 32'h7, FETCH_NORMAL, 0, 0), p);  // dirty victim flushes
    send_op(mk_op(OP_MARK_DIRTY, 0, 0, 0, 0, 6'd63), p);
    send_op(mk_op(OP_MARK_CLEAN, 0, 0, 0, 0, 6'd63), p);
    send_op(mk_op(OP_INVALIDATE, 16'h0000, 0, 0, 0, 0), p);
    send_op(mk_op(OP_INVALIDATE, 16'hFFFF, 0, 0, 0, 0), p);
    r = mk_op(OP_GET, 0, 0, 0, 0, 0);
    r.op = 3'd7;
    send_op(r, p);
    r.op = 3'd5;
    send_op(r, p);
    write_ram_dev(16'h0002);
    send_op(mk_op(OP_PUT, 0, 0, 0, 0, 6'd1), p);                     // releases with the RAM device set to 2
    send_op(mk_op(OP_PUT, 0, 0, 0, 0, 6'd2), p);
    send_op(mk_op(OP_PUT, 0, 0, 0, 0, 6'd3), p);
  endtask

  task automatic test_all_held();
    rsp_t p;
    int held_slots [$];
    for (int i = 0; i < NENT + 1; i++) begin
      send_op(mk_op(OP_GET, 16'h0005, 32'h100 + i, FETCH_NORMAL, 0, 0), p);
      if (p.status == ST_OK && !p.hit) held_slots.push_back(p.slot);
    end
    for (int i = 0; i < NENT; i++) begin
      if (sh_cnt[i] > 0)
        send_op(mk_op(OP_PUT, 0, 0, 0, 1'($urandom_range(0, 1)), i[5:0]), p);
    end
  endtask

  // Drive one entry to the count limit and past it; it stays held afterwards
  task automatic test_count_overflow();
    rsp_t p;
    send_op(mk_op(OP_GET, 16'h0003, 32'hABCD, 2'd1, 0, 0), p);
    for (int i = 0; i < CNT_MAX + 1; i++)
      send_op(mk_op(OP_GET, 16'h0003, 32'hABCD, 2'd1, 0, 0), p);
  endtask

  function automatic req_t random_op();
    req_t r;
    int k, s, n;
    r.op = OP_GET;
    r.dev = 16'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) r.dev = 16'($urandom());
    r.block_num = $urandom_range(0, 23);
    if ($urandom_range(0, 9) == 0) r.block_num = $urandom();
    k = $urandom_range(0, 9);
    r.fetch_mode = (k < 5) ? 2'd0 : (k < 7) ? 2'd1 : (k < 9) ? 2'd2 : 2'd3;
    r.no_reuse = 1'($urandom_range(0, 1));
    r.slot_in = 6'($urandom_range(0, NENT - 1));
    k = $urandom_range(0, 99);
    if (sh_held > 40) k = 50;
    if (k < 45) begin
      r.op = OP_GET;
    end else if (k < 80) begin
      r.op = OP_PUT;
      n = 0;
      s = -1;
      for (int i = 0; i < NENT; i++) begin
        if (sh_cnt[i] > 0) begin
          n++;
          if ($urandom_range(1, n) == 1) s = i;
        end
      end
      if (s >= 0 && $urandom_range(0, 9) != 0) r.slot_in = s[5:0];
    end else if (k < 88) begin
      r.op = OP_MARK_DIRTY;
    end else if (k < 92) begin
      r.op = OP_MARK_CLEAN;
    end else if (k < 95) begin
      r.op = OP_INVALIDATE;
    end else begin
      r.op = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  task automatic test_random(input int n);
    rsp_t p;
    repeat (n) send_op(random_op(), p);
  endtask

  task automatic test_backpressure();
    wait_drained();
    rsp_hold_cycles = 200;
    test_random(12);
    wait_drained();
    repeat (2) test_random(8);
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    fail_cnt = 0;
    item_cnt = 0;
    rsp_cnt = 0;
    hit_cnt = 0;
    miss_cnt = 0;
    flush_cnt = 0;
    full_cnt = 0;
    ovf_cnt = 0;
    unheld_cnt = 0;
    rsp_hold_cycles = 0;
    no_idle = 1'b0;
    for (int i = 0; i < NENT; i++) begin
      sh_dev[i] = '0;
      sh_blk[i] = '0;
      sh_valid[i] = 1'b0;
      sh_cnt[i] = 0;
      sh_dirty[i] = 1'b0;
      sh_next[i] = i + 1;
      sh_prev[i] = (i == 0) ? NENT : i - 1;
    end
    sh_head = 0;
    sh_tail = NENT - 1;
    sh_held = 0;
    sh_ram_dev = 16'hFFFF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_all_held();
    test_count_overflow();
    write_ram_dev(16'h0000);
    test_random(100);
    test_backpressure();
    write_ram_dev(16'hFFFF);
    no_idle = 1'b1;
    test_random(80);
    no_idle = 1'b0;
    write_ram_dev(16'h0001);
    test_random(80);
    write_ram_dev(16'($urandom()));
    test_random(60);

    wait_drained();
    repeat (300) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
      fail_cnt++;
    end
    $display("covered %0d requests, %0d responses: %0d hits, %0d reads, %0d flushes",
             item_cnt, rsp_cnt, hit_cnt, miss_cnt, flush_cnt);
    $display("all-held %0d, count overflow %0d, unheld put %0d",
             full_cnt, ovf_cnt, unheld_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_stream_if.sv
hw/rtl/bbc_ram.sv
hw/rtl/bbc_tag_cmp.sv
hw/rtl/block_buffer_cache_lru_unit.sv
verif/tb_block_buffer_cache_lru_unit.sv
